@@ src/alm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the array linked list manager: store size, link encoding,
// command codes, beat types, control states and the link reset pattern.
package alm_pkg;

    localparam int NODE_COUNT = 16;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int LINK_W     = $clog2(NODE_COUNT + 1);
    localparam int STEP_W     = $clog2(NODE_COUNT + 1);
    localparam int DATA_W     = 32;
    localparam int LNK_RAM_W  = 2 * LINK_W;

    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NODE_COUNT);

    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_REVERSE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               list_sel;
        logic signed [31:0] item_value;
        logic [3:0]         node_index;
    } t_in;

    typedef struct packed {
        logic               status;
        logic [4:0]         head_index;
        logic [4:0]         tail_index;
        logic signed [31:0] read_value;
        logic [4:0]         read_next;
        logic [4:0]         read_prev;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_NEXT,
        S_APP_TAIL,
        S_APP_LINK,
        S_REV,
        S_RDATA,
        S_DONE
    } t_state;

    function automatic logic is_node(input logic [LINK_W-1:0] link);
        return link < LINK_W'(NODE_COUNT);
    endfunction

    // {next, prev} of a link entry never written since reset
    function automatic logic [LNK_RAM_W-1:0] lnk_reset(input logic [IDX_W-1:0] idx);
        logic [LINK_W-1:0] nxt;
        nxt = (idx == IDX_W'(NODE_COUNT - 1)) ? LINK_NONE : LINK_W'(idx) + LINK_W'(1);
        return {nxt, LINK_NONE};
    endfunction

endpackage

@@ src/array_linked_list_manager.sv @@
`timescale 1ns / 1ps
// Two doubly linked lists and a free chain over a 16-node store (alm_pkg, alm_ram).
// A full append, unused code or empty reverse goes straight to its result beat; read, append
// and reverse first use the RAMs, a reverse walking the list one node per cycle.
// Ready returns when the beat is registered, so one command is in progress at a time.
// A new command is taken while the previous beat waits; its beat holds until that one leaves.
// Sync active-low reset: lists empty, free chain 0..15, link RAM clean via valid bits.
module array_linked_list_manager (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  alm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output alm_pkg::t_out o_out_data
);
    import alm_pkg::*;

    t_state              r_state, n_state;
    logic                r_sel, n_sel;
    logic [DATA_W-1:0]   r_value, n_value;
    logic [LINK_W-1:0]   r_free_head, n_free_head;
    logic [LINK_W-1:0]   r_head [2];
    logic [LINK_W-1:0]   n_head [2];
    logic [LINK_W-1:0]   r_tail [2];
    logic [LINK_W-1:0]   n_tail [2];
    logic [NODE_COUNT-1:0] r_lnk_vld, n_lnk_vld;
    logic                r_rd_vld;
    logic [IDX_W-1:0]    r_rd_addr;
    logic [LINK_W-1:0]   r_new, n_new;
    logic [LINK_W-1:0]   r_nf, n_nf;
    logic [LINK_W-1:0]   r_tprev, n_tprev;
    logic [LINK_W-1:0]   r_cur, n_cur;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic                r_status, n_status;
    logic [DATA_W-1:0]   r_rval, n_rval;
    logic [LINK_W-1:0]   r_rnext, n_rnext;
    logic [LINK_W-1:0]   r_rprev, n_rprev;
    t_out                r_out, n_out;
    logic                r_out_valid, n_out_valid;

    logic                 lnk_rd_en, lnk_wr_en, dat_rd_en, dat_wr_en;
    logic [IDX_W-1:0]     lnk_rd_addr, lnk_wr_addr, dat_rd_addr, dat_wr_addr;
    logic [LNK_RAM_W-1:0] lnk_wr_data, lnk_ram_q, lnk_q;
    logic [DATA_W-1:0]    dat_q;
    logic [LINK_W-1:0]    q_next, q_prev;

    alm_ram #(.WIDTH(LNK_RAM_W), .DEPTH(NODE_COUNT)) u_lnk_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lnk_wr_en),
        .i_wr_addr (lnk_wr_addr),
        .i_wr_data (lnk_wr_data),
        .i_rd_en   (lnk_rd_en),
        .i_rd_addr (lnk_rd_addr),
        .o_rd_data (lnk_ram_q)
    );

    alm_ram #(.WIDTH(DATA_W), .DEPTH(NODE_COUNT)) u_dat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (dat_wr_en),
        .i_wr_addr (dat_wr_addr),
        .i_wr_data (r_value),
        .i_rd_en   (dat_rd_en),
        .i_rd_addr (dat_rd_addr),
        .o_rd_data (dat_q)
    );

    assign lnk_q  = r_rd_vld ? lnk_ram_q : lnk_reset(r_rd_addr);
    assign q_next = lnk_q[LNK_RAM_W-1:LINK_W];
    assign q_prev = lnk_q[LINK_W-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_head[0]   <= LINK_NONE;
            r_head[1]   <= LINK_NONE;
            r_tail[0]   <= LINK_NONE;
            r_tail[1]   <= LINK_NONE;
            r_lnk_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_lnk_vld   <= n_lnk_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_value  <= n_value;
        r_new    <= n_new;
        r_nf     <= n_nf;
        r_tprev  <= n_tprev;
        r_cur    <= n_cur;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_rval   <= n_rval;
        r_rnext  <= n_rnext;
        r_rprev  <= n_rprev;
        r_out    <= n_out;
        if (lnk_rd_en) begin
            r_rd_vld  <= r_lnk_vld[lnk_rd_addr];
            r_rd_addr <= lnk_rd_addr;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_value     = r_value;
        n_free_head = r_free_head;
        n_head      = r_head;
        n_tail      = r_tail;
        n_lnk_vld   = r_lnk_vld;
        n_new       = r_new;
        n_nf        = r_nf;
        n_tprev     = r_tprev;
        n_cur       = r_cur;
        n_steps     = r_steps;
        n_status    = r_status;
        n_rval      = r_rval;
        n_rnext     = r_rnext;
        n_rprev     = r_rprev;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        lnk_rd_en   = 1'b0;
        lnk_rd_addr = '0;
        lnk_wr_en   = 1'b0;
        lnk_wr_addr = '0;
        lnk_wr_data = '0;
        dat_rd_en   = 1'b0;
        dat_rd_addr = '0;
        dat_wr_en   = 1'b0;
        dat_wr_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_sel    = i_in_data.list_sel;
                    n_value  = i_in_data.item_value;
                    n_status = STATUS_DONE;
                    n_rval   = '0;
                    n_rnext  = LINK_NONE;
                    n_rprev  = LINK_NONE;
                    n_state  = S_DONE;
                    unique case (i_in_data.cmd)
                        CMD_APPEND: begin
                            if (!is_node(r_free_head)) begin
                                n_status = STATUS_FULL;
                            end else begin
                                lnk_rd_en   = 1'b1;
                                lnk_rd_addr = r_free_head[IDX_W-1:0];
                                n_new       = r_free_head;
                                n_state     = S_APP_NEXT;
                            end
                        end
                        CMD_REVERSE: begin
                            if (is_node(r_head[i_in_data.list_sel])) begin
                                lnk_rd_en   = 1'b1;
                                lnk_rd_addr = r_head[i_in_data.list_sel][IDX_W-1:0];
                                n_cur       = r_head[i_in_data.list_sel];
                                n_steps     = STEP_W'(1);
                                n_state     = S_REV;
                            end else begin
                                n_head[i_in_data.list_sel] = r_tail[i_in_data.list_sel];
                                n_tail[i_in_data.list_sel] = r_head[i_in_data.list_sel];
                            end
                        end
                        CMD_READ: begin
                            lnk_rd_en   = 1'b1;
                            lnk_rd_addr = i_in_data.node_index;
                            dat_rd_en   = 1'b1;
                            dat_rd_addr = i_in_data.node_index;
                            n_state     = S_RDATA;
                        end
                        default: ;
                    endcase
                end
            end

            S_APP_NEXT: begin
                n_nf  = q_next;
                n_cur = r_tail[r_sel];
                if (is_node(r_tail[r_sel])) begin
                    lnk_rd_en   = 1'b1;
                    lnk_rd_addr = r_tail[r_sel][IDX_W-1:0];
                end
                n_state = S_APP_TAIL;
            end

            S_APP_TAIL: begin
                n_tprev     = q_prev;
                lnk_wr_en   = 1'b1;
                lnk_wr_addr = r_new[IDX_W-1:0];
                lnk_wr_data = {LINK_NONE, is_node(r_cur) ? r_cur : LINK_NONE};
                n_lnk_vld[r_new[IDX_W-1:0]] = 1'b1;
                dat_wr_en   = 1'b1;
                dat_wr_addr = r_new[IDX_W-1:0];
                n_free_head = r_nf;
                n_tail[r_sel] = r_new;
                if (!is_node(r_head[r_sel])) begin
                    n_head[r_sel] = r_new;
                end
                n_state = is_node(r_cur) ? S_APP_LINK : S_DONE;
            end

            S_APP_LINK: begin
                lnk_wr_en   = 1'b1;
                lnk_wr_addr = r_cur[IDX_W-1:0];
                lnk_wr_data = {r_new, r_tprev};
                n_lnk_vld[r_cur[IDX_W-1:0]] = 1'b1;
                n_state     = S_DONE;
            end

            S_REV: begin
                // swap links of current node, follow the old next
                lnk_wr_en   = 1'b1;
                lnk_wr_addr = r_cur[IDX_W-1:0];
                lnk_wr_data = {q_prev, q_next};
                n_lnk_vld[r_cur[IDX_W-1:0]] = 1'b1;
                if (is_node(q_next) && (r_steps < STEP_W'(NODE_COUNT))) begin
                    lnk_rd_en   = 1'b1;
                    lnk_rd_addr = q_next[IDX_W-1:0];
                    n_cur       = q_next;
                    n_steps     = r_steps + STEP_W'(1);
                end else begin
                    n_head[r_sel] = r_tail[r_sel];
                    n_tail[r_sel] = r_head[r_sel];
                    n_state       = S_DONE;
                end
            end

            S_RDATA: begin
                n_rval  = dat_q;
                n_rnext = is_node(q_next) ? q_next : LINK_NONE;
                n_rprev = is_node(q_prev) ? q_prev : LINK_NONE;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.status     = r_status;
                    n_out.head_index = is_node(r_head[r_sel]) ? r_head[r_sel] : LINK_NONE;
                    n_out.tail_index = is_node(r_tail[r_sel]) ? r_tail[r_sel] : LINK_NONE;
                    n_out.read_value = r_rval;
                    n_out.read_next  = r_rnext;
                    n_out.read_prev  = r_rprev;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

@@ src/alm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module alm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ tb/tb_array_linked_list_manager.sv @@
`timescale 1ns / 1ps
// Testbench for array_linked_list_manager: a directed table, then random commands.
// Typed rows are checked as given, the rest against a model of the lists and free chain.
// Depends on alm_pkg and the DUT sources only.
module tb_array_linked_list_manager;
    import alm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N_RAND    = 1050;
    localparam int HOLD_AT   = 300;
    localparam int HOLD_CYC  = 150;
    localparam int CALM_FROM = 900;

    typedef logic [LINK_W-1:0] t_link;

    typedef struct {
        t_in  item;
        bit   typed;
        t_out want;
    } t_row;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    // list model
    logic [DATA_W-1:0] nd_data    [NODE_COUNT];
    t_link             nd_next    [NODE_COUNT];
    t_link             nd_prev    [NODE_COUNT];
    bit                nd_written [NODE_COUNT];
    t_link             free_hd;
    t_link             lst_head   [2];
    t_link             lst_tail   [2];

    t_out exp_beats [$];
    t_row dir_rows  [$];
    int   err_cnt  = 0;
    bit   calm     = 1'b0;
    bit   hold_req = 1'b0;

    always #6 clk = ~clk;

    array_linked_list_manager u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    function automatic t_out apply_list_cmd(input t_in it);
        t_out  r;
        t_link slot;
        t_link tl;
        t_link cur;
        t_link tmp;
        int    steps;
        logic  s;
        s = it.list_sel;
        r.status     = STATUS_DONE;
        r.read_value = '0;
        r.read_next  = LINK_NONE;
        r.read_prev  = LINK_NONE;
        case (it.cmd)
            CMD_APPEND: begin
                slot = free_hd;
                tl   = lst_tail[s];
                if (slot >= NODE_COUNT) begin
                    r.status = STATUS_FULL;
                end else begin
                    free_hd = nd_next[slot[IDX_W-1:0]];
                    nd_data[slot[IDX_W-1:0]]    = it.item_value;
                    nd_written[slot[IDX_W-1:0]] = 1'b1;
                    nd_next[slot[IDX_W-1:0]]    = LINK_NONE;
                    nd_prev[slot[IDX_W-1:0]]    = (tl < NODE_COUNT) ? tl : LINK_NONE;
                    if (tl < NODE_COUNT) begin
                        nd_next[tl[IDX_W-1:0]] = slot;
                    end
                    lst_tail[s] = slot;
                    if (lst_head[s] >= NODE_COUNT) begin
                        lst_head[s] = slot;
                    end
                end
            end
            CMD_REVERSE: begin
                cur   = lst_head[s];
                steps = 0;
                while (cur < NODE_COUNT && steps < NODE_COUNT) begin
                    tmp = nd_prev[cur[IDX_W-1:0]];
                    nd_prev[cur[IDX_W-1:0]] = nd_next[cur[IDX_W-1:0]];
                    nd_next[cur[IDX_W-1:0]] = tmp;
                    cur = nd_prev[cur[IDX_W-1:0]];
                    steps++;
                end
                tmp         = lst_head[s];
                lst_head[s] = lst_tail[s];
                lst_tail[s] = tmp;
            end
            CMD_READ: begin
                r.read_value = nd_data[it.node_index];
                r.read_next  = (nd_next[it.node_index] < NODE_COUNT) ?
                               nd_next[it.node_index] : LINK_NONE;
                r.read_prev  = (nd_prev[it.node_index] < NODE_COUNT) ?
                               nd_prev[it.node_index] : LINK_NONE;
            end
            default: ;
        endcase
        r.head_index = (lst_head[s] < NODE_COUNT) ? lst_head[s] : LINK_NONE;
        r.tail_index = (lst_tail[s] < NODE_COUNT) ? lst_tail[s] : LINK_NONE;
        return r;
    endfunction

    function automatic void add_row(input logic [1:0] cmd, input logic sel,
                                    input logic [31:0] val, input logic [3:0] idx,
                                    input bit typed, input logic st,
                                    input t_link hd, input t_link tl);
        t_row row;
        row.item.cmd        = cmd;
        row.item.list_sel   = sel;
        row.item.item_value = val;
        row.item.node_index = idx;
        row.typed           = typed;
        row.want.status     = st;
        row.want.head_index = hd;
        row.want.tail_index = tl;
        row.want.read_value = '0;
        row.want.read_next  = LINK_NONE;
        row.want.read_prev  = LINK_NONE;
        dir_rows.push_back(row);
    endfunction

    // called right after the falling edge or after the previous accept
    task automatic push_cmd(input t_in it, input bit typed, input t_out want);
        int   gap;
        t_out pred;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid = 1'b0;
            end
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data  = it;
        do @(posedge clk); while (!in_ready);
        pred = apply_list_cmd(it);
        exp_beats.push_back(typed ? want : pred);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            err_cnt++;
            $display("%0t ns: %s expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endtask

    task automatic check_beat(input t_out got);
        t_out want;
        if (exp_beats.size() == 0) begin
            err_cnt++;
            $display("%0t ns: result beat with none expected, got %h", $time, got);
        end else begin
            want = exp_beats.pop_front();
            cmp_field("status",     32'(want.status),     32'(got.status));
            cmp_field("head_index", 32'(want.head_index), 32'(got.head_index));
            cmp_field("tail_index", 32'(want.tail_index), 32'(got.tail_index));
            cmp_field("read_value", want.read_value,      got.read_value);
            cmp_field("read_next",  32'(want.read_next),  32'(got.read_next));
            cmp_field("read_prev",  32'(want.read_prev),  32'(got.read_prev));
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_beat(out_data);
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        int hold;
        bit held;
        stall = 0;
        held  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req && !held) begin
                out_ready = 1'b0;
                for (hold = 1; hold < HOLD_CYC; hold++) @(negedge clk);
                held = 1'b1;
            end else if (stall > 0) begin
                out_ready = 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_ready = 1'b0;
                stall = $urandom_range(0, 7);
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        t_in  it;
        t_out none;
        int   k;
        int   pick;

        for (k = 0; k < NODE_COUNT; k++) begin
            nd_data[k]    = '0;
            nd_next[k]    = (k == NODE_COUNT - 1) ? LINK_NONE : t_link'(k + 1);
            nd_prev[k]    = LINK_NONE;
            nd_written[k] = 1'b0;
        end
        free_hd     = '0;
        lst_head[0] = LINK_NONE;
        lst_head[1] = LINK_NONE;
        lst_tail[0] = LINK_NONE;
        lst_tail[1] = LINK_NONE;
        none        = '0;

        add_row(CMD_REVERSE, 1'b0, 32'h0,         4'h0, 1, STATUS_DONE, LINK_NONE, LINK_NONE);
        add_row(CMD_UNUSED,  1'b1, 32'hFFFF_FFFF, 4'hF, 1, STATUS_DONE, LINK_NONE, LINK_NONE);
        add_row(CMD_APPEND,  1'b0, 32'h7FFF_FFFF, 4'h0, 1, STATUS_DONE, 5'd0, 5'd0);
        add_row(CMD_APPEND,  1'b1, 32'h8000_0000, 4'hF, 1, STATUS_DONE, 5'd1, 5'd1);
        add_row(CMD_APPEND,  1'b0, 32'hFFFF_FFFF, 4'h5, 1, STATUS_DONE, 5'd0, 5'd2);
        add_row(CMD_READ,    1'b0, 32'h0,         4'h0, 0, STATUS_DONE, 5'd0, 5'd0);
        add_row(CMD_READ,    1'b1, 32'hFFFF_FFFF, 4'h1, 0, STATUS_DONE, 5'd0, 5'd0);
        add_row(CMD_REVERSE, 1'b0, 32'h0,         4'h0, 0, STATUS_DONE, 5'd0, 5'd0);
        add_row(CMD_READ,    1'b0, 32'h0,         4'h2, 0, STATUS_DONE, 5'd0, 5'd0);
        for (k = 0; k < 13; k++) begin
            add_row(CMD_APPEND, 1'b1, 32'(k) * 32'h1357_9BDF, 4'(k), 0,
                    STATUS_DONE, 5'd0, 5'd0);
        end
        // store now full; list 0 reversed to 2 -> 0
        add_row(CMD_APPEND,  1'b0, 32'h1234_5678, 4'h0, 1, STATUS_FULL, 5'd2, 5'd0);
        add_row(CMD_READ,    1'b1, 32'h0,         4'hF, 0, STATUS_DONE, 5'd0, 5'd0);
        add_row(CMD_REVERSE, 1'b1, 32'h0,         4'h0, 0, STATUS_DONE, 5'd0, 5'd0);
        add_row(CMD_READ,    1'b1, 32'h0,         4'hF, 0, STATUS_DONE, 5'd0, 5'd0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[k]) begin
            push_cmd(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end

        for (k = 0; k < N_RAND; k++) begin
            if (k == HOLD_AT) hold_req = 1'b1;
            if (k == CALM_FROM) calm = 1'b1;
            it.list_sel   = 1'($urandom_range(0, 1));
            it.node_index = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 7))
                0:       it.item_value = 32'h8000_0000;
                1:       it.item_value = 32'h7FFF_FFFF;
                2:       it.item_value = 32'hFFFF_FFFF;
                default: it.item_value = $urandom;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                it.cmd = CMD_APPEND;
            end else if (pick < 55) begin
                it.cmd = CMD_REVERSE;
            end else if (pick < 95) begin
                it.cmd = CMD_READ;
                while (!nd_written[it.node_index]) it.node_index = 4'($urandom_range(0, 15));
            end else begin
                it.cmd = CMD_UNUSED;
            end
            push_cmd(it, 1'b0, none);
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (exp_beats.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
